>>> rtl/pure_pursuit_steering_top_defines.svh
// Assertion macros shared by the pure pursuit steering RTL.
`ifndef PURE_PURSUIT_STEERING_TOP_DEFINES_SVH
`define PURE_PURSUIT_STEERING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset.
`define PPS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pure pursuit steering check failed");
// Check that a condition never holds out of reset.
`define PPS_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pure pursuit steering forbidden condition seen");
`else
`define PPS_ASSERT(name, clk, rst_n, prop)
`define PPS_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

>>> rtl/ppsteer_pkg.sv
// Types, constants and helpers shared by the pure pursuit steering block.
package ppsteer_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned D2_W      = 64;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned TIME_FRAC = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LA_PROD_W = DATA_W + TIME_W;
  localparam int unsigned LA_T_W    = LA_PROD_W - TIME_FRAC;

  localparam logic [CFG_W-1:0]  MIN_LA_RST  = 31'd19661;
  localparam logic [CFG_W-1:0]  MAX_LA_RST  = 31'd65536;
  localparam logic [TIME_W-1:0] LA_TIME_RST = 16'd256;

  localparam logic [DATA_W-1:0] RATE_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] RATE_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LA  = 2'd0,
    CFG_MAX_LA  = 2'd1,
    CFG_LA_TIME = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LA_MUL,
    ST_LA_CLAMP,
    ST_LA_SQ,
    ST_LA_SET,
    ST_SQX,
    ST_SQY,
    ST_CMP,
    ST_RATE_MUL,
    ST_RATE_LOAD,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    MUL_LA,
    MUL_DSQ,
    MUL_X,
    MUL_Y,
    MUL_RATE
  } mul_sel_e;

  typedef struct packed {
    logic     idle;
    mul_sel_e mul_sel;
    logic     la_clamp;
    logic     la_set;
    logic     acc_load;
    logic     cmp;
    logic     rate_chk;
    logic     div_start;
    logic     finish;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic in_run;
    logic found;
    logic last;
    logic zero;
    logic div_busy;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic busy;
    logic sat;
  } div_stat_t;

  function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] v);
    abs32 = v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

>>> rtl/ppsteer_if.sv
// Valid/ready channel interfaces for path points and steering results.
interface ppsteer_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] current_speed;
  logic [31:0] target_speed;
  logic        last_point;

  modport source (output valid, point_x, point_y, current_speed, target_speed,
                  last_point, input ready);
  modport sink (input valid, point_x, point_y, current_speed, target_speed,
                last_point, output ready);
endinterface

interface ppsteer_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] angular_rate;
  logic [31:0] goal_x;
  logic [31:0] goal_y;
  logic        reached_lookahead;

  modport source (output valid, angular_rate, goal_x, goal_y, reached_lookahead,
                  input ready);
  modport sink (input valid, angular_rate, goal_x, goal_y, reached_lookahead,
                output ready);
endinterface

>>> rtl/ppsteer_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
module ppsteer_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  import ppsteer_pkg::*;

  logic [D2_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= D2_W'(a_i) * D2_W'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> rtl/ppsteer_div.sv
// Restoring divider, one quotient bit per cycle, with saturation detect.
`include "pure_pursuit_steering_top_defines.svh"

module ppsteer_div #(
  parameter int unsigned DIVIDEND_W = 80
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [63:0]           divisor_i,
  output logic [31:0]           quot_o,
  output ppsteer_pkg::div_stat_t stat_o
);
  import ppsteer_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [D2_W-1:0]       rem_q, divisor_q, rem_nx;
  logic [DIVIDEND_W-1:0] num_q;
  logic [DATA_W-1:0]     quot_q;
  logic                  ovf_q;
  logic                  busy;
  logic [D2_W:0]         rem_sh;
  logic [D2_W+1:0]       diff;
  logic                  ge;

  assign busy   = (cnt_q != '0);
  assign rem_sh = {rem_q, num_q[DIVIDEND_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_q};
  assign ge     = ~diff[D2_W+1];
  assign rem_nx = ge ? diff[D2_W-1:0] : rem_sh[D2_W-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      num_q     <= dividend_i;
      divisor_q <= divisor_i;
      quot_q    <= '0;
      ovf_q     <= 1'b0;
    end else if (busy) begin
      rem_q  <= rem_nx;
      num_q  <= {num_q[DIVIDEND_W-2:0], 1'b0};
      quot_q <= {quot_q[DATA_W-2:0], ge};
      ovf_q  <= ovf_q | quot_q[DATA_W-1];
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy;
  assign stat_o.sat  = ovf_q | quot_q[DATA_W-1];

  `PPS_ASSERT(a_start_busy, clk_i, rst_ni, start_i |=> busy)
  `PPS_ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, start_i && busy)
  `PPS_ASSERT(a_rem_below_divisor, clk_i, rst_ni, busy |-> (rem_q < divisor_q))

endmodule

>>> rtl/ppsteer_seq.sv
// Sequencer that steps the shared multiplier and divider through each point.
module ppsteer_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ppsteer_pkg::seq_stat_t stat_i,
  output ppsteer_pkg::ctrl_t     ctrl_o
);
  import ppsteer_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_fire) begin
          if (!stat_i.in_run) begin
            state_d = ST_LA_MUL;
          end else if (!stat_i.found) begin
            state_d = ST_SQX;
          end else if (stat_i.in_last) begin
            state_d = ST_RATE_MUL;
          end
        end
      end
      ST_LA_MUL:    state_d = ST_LA_CLAMP;
      ST_LA_CLAMP:  state_d = ST_LA_SQ;
      ST_LA_SQ:     state_d = ST_LA_SET;
      ST_LA_SET:    state_d = ST_SQY;
      ST_SQX:       state_d = ST_SQY;
      ST_SQY:       state_d = ST_CMP;
      ST_CMP:       state_d = stat_i.last ? ST_RATE_MUL : ST_IDLE;
      ST_RATE_MUL:  state_d = ST_RATE_LOAD;
      ST_RATE_LOAD: state_d = stat_i.zero ? ST_FINISH : ST_DIV;
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_sel = MUL_X;
    case (state_q)
      ST_IDLE:      ctrl_o.idle = 1'b1;
      ST_LA_MUL:    ctrl_o.mul_sel = MUL_LA;
      ST_LA_CLAMP:  ctrl_o.la_clamp = 1'b1;
      ST_LA_SQ:     ctrl_o.mul_sel = MUL_DSQ;
      ST_LA_SET:    ctrl_o.la_set = 1'b1;
      ST_SQX:       ctrl_o.mul_sel = MUL_X;
      ST_SQY: begin
        ctrl_o.mul_sel  = MUL_Y;
        ctrl_o.acc_load = 1'b1;
      end
      ST_CMP:       ctrl_o.cmp = 1'b1;
      ST_RATE_MUL: begin
        ctrl_o.mul_sel  = MUL_RATE;
        ctrl_o.rate_chk = 1'b1;
      end
      ST_RATE_LOAD: ctrl_o.div_start = !stat_i.zero;
      ST_DIV:       ctrl_o.idle = 1'b0;
      ST_FINISH:    ctrl_o.finish = stat_i.out_free;
      default:      ctrl_o.idle = 1'b0;
    endcase
  end

endmodule

>>> rtl/pure_pursuit_steering_top.sv
// Pure pursuit steering: lookahead point selection and angular rate command.
//
// Path points arrive on in_i, already in the robot frame, one point per
// transaction; last_point marks the end of a run. The first point of a run
// latches current and target speed and forms the clamped lookahead distance.
// Each point is compared against it until one reaches it; that point, or the
// last one, is kept. The run's final point yields one transaction on out_o.
// All arithmetic goes through one registered 32x32 multiplier and one
// restoring divider under a small sequencer, so in_i.ready is low while a
// point is in work. The first point of a run passes the lookahead states
// (multiply, clamp, square, set) and its compare; each later point is
// squared and compared until the lookahead is reached, then only taken.
// The last point adds the rate product and the one-bit-per-cycle division
// (skipped within 1 mm). The result sits in an output register: the next run
// is taken while it waits; only that run's finish stalls on a full register.
// Reset is asynchronous and active low; it restores the register defaults
// and leaves the block outside any run with no result pending.
`include "pure_pursuit_steering_top_defines.svh"

module pure_pursuit_steering_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ppsteer_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ppsteer_pkg::CFG_W-1:0]        cfg_data_i,
  ppsteer_in_if.sink                           in_i,
  ppsteer_out_if.source                        out_o
);
  import ppsteer_pkg::*;

  localparam int unsigned DIV_W = D2_W + FRAC_BITS;
  localparam logic [D2_W-1:0] NEAR_LIMIT =
    D2_W'((128'd1 << (2 * FRAC_BITS)) / 128'd1000000);

  ctrl_t     ctrl;
  seq_stat_t seq_stat;
  div_stat_t div_stat;

  logic [CFG_W-1:0]  min_la_q, max_la_q;
  logic [TIME_W-1:0] la_time_q;

  logic              in_run_q, found_q, out_valid_q;
  logic [DATA_W-1:0] px_q, py_q, cur_q, held_speed_q, held_x_q, held_y_q;
  logic              last_q, zero_q;
  logic [CFG_W-1:0]  d_q, d_n;
  logic [D2_W-1:0]   lsq_q, acc_q, held_d2_q, sum;
  logic [LA_T_W-1:0] la_t;
  logic [DATA_W-1:0] mul_a, mul_b, quot, rate;
  logic [D2_W-1:0]   mul_p;
  logic [DIV_W-1:0]  dividend;
  logic              rate_neg, in_fire, out_free;
  logic [DATA_W-1:0] out_rate_q, out_x_q, out_y_q;
  logic              out_found_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign seq_stat.in_fire  = in_fire;
  assign seq_stat.in_last  = in_i.last_point;
  assign seq_stat.in_run   = in_run_q;
  assign seq_stat.found    = found_q;
  assign seq_stat.last     = last_q;
  assign seq_stat.zero     = zero_q;
  assign seq_stat.div_busy = div_stat.busy;
  assign seq_stat.out_free = out_free;

  ppsteer_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (seq_stat),
    .ctrl_o (ctrl)
  );

  assign in_i.ready = ctrl.idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_la_q  <= MIN_LA_RST;
      max_la_q  <= MAX_LA_RST;
      la_time_q <= LA_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_LA:  min_la_q  <= cfg_data_i;
        CFG_MAX_LA:  max_la_q  <= cfg_data_i;
        CFG_LA_TIME: la_time_q <= cfg_data_i[TIME_W-1:0];
        default:     la_time_q <= la_time_q;
      endcase
    end
  end

  always_comb begin
    case (ctrl.mul_sel)
      MUL_LA: begin
        mul_a = abs32(cur_q);
        mul_b = DATA_W'(la_time_q);
      end
      MUL_DSQ: begin
        mul_a = DATA_W'(d_q);
        mul_b = DATA_W'(d_q);
      end
      MUL_X: begin
        mul_a = abs32(px_q);
        mul_b = abs32(px_q);
      end
      MUL_Y: begin
        mul_a = abs32(py_q);
        mul_b = abs32(py_q);
      end
      MUL_RATE: begin
        mul_a = abs32(held_speed_q);
        mul_b = abs32(held_y_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ppsteer_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign la_t = mul_p[LA_PROD_W-1:TIME_FRAC];

  always_comb begin
    if (cur_q[DATA_W-1]) begin
      d_n = (min_la_q > max_la_q) ? max_la_q : min_la_q;
    end else if (la_t < LA_T_W'(min_la_q)) begin
      d_n = min_la_q;
    end else if (la_t > LA_T_W'(max_la_q)) begin
      d_n = max_la_q;
    end else begin
      d_n = la_t[CFG_W-1:0];
    end
  end

  assign sum      = acc_q + mul_p;
  assign dividend = {mul_p[D2_W-2:0], 1'b0, {FRAC_BITS{1'b0}}};

  ppsteer_div #(
    .DIVIDEND_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (dividend),
    .divisor_i  (held_d2_q),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  assign rate_neg = held_speed_q[DATA_W-1] ^ held_y_q[DATA_W-1];

  always_comb begin
    if (zero_q) begin
      rate = '0;
    end else if (div_stat.sat) begin
      rate = rate_neg ? RATE_MIN : RATE_MAX;
    end else begin
      rate = rate_neg ? (~quot + 1'b1) : quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.la_set) begin
        in_run_q <= 1'b1;
        found_q  <= 1'b0;
      end else if (ctrl.cmp && (sum >= lsq_q)) begin
        found_q <= 1'b1;
      end else if (ctrl.finish) begin
        in_run_q <= 1'b0;
        found_q  <= 1'b0;
      end
      if (ctrl.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q   <= in_i.point_x;
      py_q   <= in_i.point_y;
      last_q <= in_i.last_point;
      if (!in_run_q) begin
        cur_q        <= in_i.current_speed;
        held_speed_q <= in_i.target_speed;
      end
    end
    if (ctrl.la_clamp) begin
      d_q <= d_n;
    end
    if (ctrl.la_set) begin
      lsq_q <= mul_p;
    end
    if (ctrl.acc_load) begin
      acc_q <= mul_p;
    end
    if (ctrl.cmp) begin
      held_x_q  <= px_q;
      held_y_q  <= py_q;
      held_d2_q <= sum;
    end
    if (ctrl.rate_chk) begin
      zero_q <= (held_d2_q <= NEAR_LIMIT);
    end
    if (ctrl.finish) begin
      out_rate_q  <= rate;
      out_x_q     <= held_x_q;
      out_y_q     <= held_y_q;
      out_found_q <= found_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.angular_rate      = out_rate_q;
  assign out_o.goal_x            = out_x_q;
  assign out_o.goal_y            = out_y_q;
  assign out_o.reached_lookahead = out_found_q;

  `PPS_ASSERT(a_found_in_run, clk_i, rst_ni, found_q |-> in_run_q)
  `PPS_ASSERT(a_found_reaches, clk_i, rst_ni, found_q |-> (held_d2_q >= lsq_q))
  `PPS_ASSERT_NEVER(a_ready_while_div, clk_i, rst_ni, div_stat.busy && in_i.ready)

endmodule

>>> tb/tb_pure_pursuit_steering_top.sv
// Self-checking testbench for pure_pursuit_steering_top: path point runs, configuration, stalls.
`timescale 1ns / 1ps

module tb_pure_pursuit_steering_top;
  import ppsteer_pkg::*;

  localparam int unsigned FRAC     = 16;
  localparam int          CLK_HALF = 5;
  localparam int          SETTLE   = 120;
  localparam int          WATCHDOG = 5000;
  localparam int          HOLD_OFF = 600;
  localparam int          RAND_PTS = 1400;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [63:0] NEAR_D2 = (64'd1 << (2 * FRAC)) / 64'd1000000;
  localparam int          ONE_M   = 1 << FRAC;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] cur;
    logic [31:0] tgt;
    logic        last;
  } path_pt_t;

  typedef struct {
    logic [31:0] rate;
    logic [31:0] gx;
    logic [31:0] gy;
    logic        reached;
  } steer_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  ppsteer_in_if  in_if ();
  ppsteer_out_if out_if ();

  pure_pursuit_steering_top #(
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Mirror of the block's registers and run state
  logic [CFG_W-1:0]  min_la_m;
  logic [CFG_W-1:0]  max_la_m;
  logic [TIME_W-1:0] la_time_m;
  bit                run_open;
  bit                goal_found;
  logic [31:0]       goal_x_m;
  logic [31:0]       goal_y_m;
  logic [63:0]       la_sq_m;
  logic [31:0]       tgt_speed_m;

  steer_res_t pending_steer_q[$];

  int  err_cnt;
  int  n_points;
  int  n_runs;
  int  n_cfg;
  int  n_checked;
  int  n_reached;
  int  n_zero_rate;
  int  n_sat;
  bit  calm;
  int  hold_req;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] dist_sq(logic [31:0] x, logic [31:0] y);
    logic [63:0] ax;
    logic [63:0] ay;
    ax = {32'd0, mag32(x)};
    ay = {32'd0, mag32(y)};
    return ax * ax + ay * ay;
  endfunction

  function automatic logic [31:0] steer_rate_of(logic [31:0] speed, logic [31:0] x,
                                                logic [31:0] y);
    logic [63:0]  d2;
    logic [63:0]  mag;
    logic [127:0] num;
    logic [127:0] quo;
    d2 = dist_sq(x, y);
    if (d2 <= NEAR_D2) return 32'd0;
    mag = {32'd0, mag32(speed)} * {32'd0, mag32(y)} * 64'd2;
    if (mag == 64'd0) return 32'd0;
    num = {64'd0, mag} << FRAC;
    quo = num / {64'd0, d2};
    if (speed[31] ^ y[31]) begin
      if (quo >= 128'h8000_0000) return RATE_MIN;
      return ~quo[31:0] + 32'd1;
    end
    if (quo > 128'h7FFF_FFFF) return RATE_MAX;
    return quo[31:0];
  endfunction

  function automatic void reset_mirror();
    min_la_m    = MIN_LA_RST;
    max_la_m    = MAX_LA_RST;
    la_time_m   = LA_TIME_RST;
    run_open    = 1'b0;
    goal_found  = 1'b0;
    goal_x_m    = '0;
    goal_y_m    = '0;
    la_sq_m     = '0;
    tgt_speed_m = '0;
  endfunction

  function automatic void mirror_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_MIN_LA:  min_la_m = data;
      CFG_MAX_LA:  max_la_m = data;
      CFG_LA_TIME: la_time_m = data[TIME_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_steering(path_pt_t p);
    logic signed [63:0] spd;
    logic signed [63:0] tm;
    logic signed [63:0] prod;
    logic [63:0]        la;
    steer_res_t         r;
    if (!run_open) begin
      spd  = {{32{p.cur[31]}}, p.cur};
      tm   = {48'd0, la_time_m};
      prod = spd * tm;
      if (prod < 0) la = {33'd0, min_la_m};
      else la = 64'(prod) >> TIME_FRAC;
      if (la < {33'd0, min_la_m}) la = {33'd0, min_la_m};
      else if (la > {33'd0, max_la_m}) la = {33'd0, max_la_m};
      la_sq_m     = la * la;
      tgt_speed_m = p.tgt;
      goal_found  = 1'b0;
      run_open    = 1'b1;
    end
    if (!goal_found) begin
      goal_x_m = p.x;
      goal_y_m = p.y;
      if (dist_sq(p.x, p.y) >= la_sq_m) goal_found = 1'b1;
    end
    if (p.last) begin
      r.rate    = steer_rate_of(tgt_speed_m, goal_x_m, goal_y_m);
      r.gx      = goal_x_m;
      r.gy      = goal_y_m;
      r.reached = goal_found;
      pending_steer_q.push_back(r);
      run_open = 1'b0;
      n_runs++;
    end
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic path_pt_t mk_pt(int x, int y, int cur, int tgt, bit last);
    path_pt_t p;
    p.x    = x;
    p.y    = y;
    p.cur  = cur;
    p.tgt  = tgt;
    p.last = last;
    return p;
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return int'($urandom_range(0, 5 * ONE_M)) - 5 * ONE_M / 2;
    if (r < 5) return int'($urandom_range(0, 80)) - 40;
    if (r < 7) return int'($urandom_range(0, 32 * ONE_M)) - 16 * ONE_M;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_cur_speed();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 3 * ONE_M);
    if (r < 8) return -int'($urandom_range(1, 2 * ONE_M));
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_tgt_speed();
    if ($urandom_range(0, 9) < 6) return int'($urandom_range(0, 4 * ONE_M)) - 2 * ONE_M;
    return $urandom;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    steer_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_steer_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: rate=%h goal=(%h,%h) reached=%b",
                   out_if.angular_rate, out_if.goal_x, out_if.goal_y,
                   out_if.reached_lookahead);
      end else begin
        e = pending_steer_q.pop_front();
        n_checked++;
        if (e.reached) n_reached++;
        if (e.rate == 32'd0) n_zero_rate++;
        if (e.rate == RATE_MAX || e.rate == RATE_MIN) n_sat++;
        if (out_if.angular_rate !== e.rate || out_if.goal_x !== e.gx ||
            out_if.goal_y !== e.gy || out_if.reached_lookahead !== e.reached) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp rate=%h goal=(%h,%h) reached=%b,",
                     e.rate, e.gx, e.gy, e.reached,
                     " got rate=%h goal=(%h,%h) reached=%b", out_if.angular_rate,
                     out_if.goal_x, out_if.goal_y, out_if.reached_lookahead);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    int quiet;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet, pending_steer_q.size());
        $display("pure_pursuit_steering_top test failed");
        $finish;
      end
    end
  end

  // Result receiver
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall = idle_len();
        if (stall == 0) stall = 1;
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_point(path_pt_t p);
    int gap;
    in_if.valid         <= 1'b1;
    in_if.point_x       <= p.x;
    in_if.point_y       <= p.y;
    in_if.current_speed <= p.cur;
    in_if.target_speed  <= p.tgt;
    in_if.last_point    <= p.last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_steering(p);
    n_points++;
    if (!calm) begin
      gap = idle_len();
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Lower valid, wait for every result, then let the block settle
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (pending_steer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    mirror_cfg(idx, data);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] min_la, logic [CFG_W-1:0] max_la,
                              logic [CFG_W-1:0] la_time);
    write_reg(CFG_MIN_LA, min_la);
    write_reg(CFG_MAX_LA, max_la);
    write_reg(CFG_LA_TIME, la_time);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic send_path_run(int len);
    path_pt_t p;
    int       x0;
    int       y0;
    int       step;
    int       drift;
    bit       noisy;
    noisy = ($urandom_range(0, 9) >= 7);
    x0    = int'($urandom_range(0, ONE_M)) - ONE_M / 2;
    y0    = int'($urandom_range(0, ONE_M)) - ONE_M / 2;
    step  = $urandom_range(ONE_M / 20, 3 * ONE_M / 5);
    drift = int'($urandom_range(0, ONE_M / 2)) - ONE_M / 4;
    for (int k = 0; k < len; k++) begin
      if (noisy) begin
        p.x = rand_coord();
        p.y = rand_coord();
      end else begin
        p.x = x0 + k * step;
        p.y = y0 + k * drift;
      end
      p.cur  = rand_cur_speed();
      p.tgt  = rand_tgt_speed();
      p.last = (k == len - 1);
      send_point(p);
    end
  endtask

  task automatic test_directed_points();
    send_point(mk_pt(0, 0, 0, ONE_M, 1'b1));
    send_point(mk_pt(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_point(mk_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    send_point(mk_pt(32'h7FFF_FFFF, 32'h8000_0000, ONE_M, 32'h7FFF_FFFF, 1'b1));
    send_point(mk_pt(65, 8, ONE_M, ONE_M, 1'b1));
    send_point(mk_pt(65, 9, ONE_M, ONE_M, 1'b1));
    send_point(mk_pt(ONE_M, 0, ONE_M, ONE_M, 1'b1));
    send_point(mk_pt(ONE_M / 10, 0, ONE_M, ONE_M, 1'b0));
    send_point(mk_pt(2 * ONE_M, ONE_M / 2, 0, 0, 1'b0));
    send_point(mk_pt(5 * ONE_M, 5 * ONE_M, 0, 0, 1'b0));
    send_point(mk_pt(0, 0, 0, 0, 1'b1));
    send_point(mk_pt(ONE_M / 10, ONE_M / 10, 2 * ONE_M, -ONE_M, 1'b0));
    send_point(mk_pt(ONE_M / 5, -3 * ONE_M / 10, 0, 0, 1'b0));
    send_point(mk_pt(3 * ONE_M / 10, ONE_M / 5, 0, 0, 1'b1));
    send_point(mk_pt(ONE_M / 5, 0, -ONE_M, ONE_M, 1'b0));
    send_point(mk_pt(20316, 1000, 0, 0, 1'b0));
    send_point(mk_pt(9 * ONE_M, 9 * ONE_M, 0, 0, 1'b1));
    send_point(mk_pt(ONE_M, ONE_M, ONE_M, 0, 1'b1));
    send_point(mk_pt(ONE_M, ONE_M, ONE_M, -3 * ONE_M, 1'b1));
  endtask

  task automatic test_cfg_extremes();
    quiesce();
    program_regs('0, '0, '0);
    send_point(mk_pt(0, 0, ONE_M, ONE_M, 1'b0));
    send_point(mk_pt(ONE_M, ONE_M, 0, 0, 1'b1));
    quiesce();
    program_regs('1, '1, 31'h0000_FFFF);
    send_point(mk_pt(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, ONE_M, 1'b0));
    send_point(mk_pt(32'h8000_0000, 32'h8000_0000, 0, 0, 1'b0));
    send_point(mk_pt(ONE_M, ONE_M, 0, 0, 1'b1));
    quiesce();
    program_regs(CFG_W'(2 * ONE_M), CFG_W'(ONE_M / 2), CFG_W'(256));
    send_point(mk_pt(3 * ONE_M / 2, 0, ONE_M, 2 * ONE_M, 1'b0));
    send_point(mk_pt(5 * ONE_M / 2, ONE_M, 0, 0, 1'b1));
    quiesce();
    write_reg(CFG_IDX_SPARE, CFG_W'($urandom));
    program_regs(CFG_W'(ONE_M / 2), CFG_W'(3 * ONE_M), 31'h7FFF_FFFF);
    send_point(mk_pt(ONE_M, ONE_M, 2 * ONE_M, ONE_M, 1'b0));
    send_point(mk_pt(4 * ONE_M, -ONE_M, 0, 0, 1'b1));
    quiesce();
    program_regs(MIN_LA_RST, MAX_LA_RST, CFG_W'(LA_TIME_RST));
  endtask

  task automatic test_random_runs();
    int target;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) begin
        quiesce();
        lo = CFG_W'($urandom_range(0, 2 * ONE_M));
        hi = CFG_W'(lo + $urandom_range(0, 3 * ONE_M));
        case ($urandom_range(0, 4))
          0: program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
          1: program_regs(hi, lo, CFG_W'($urandom_range(0, 4 * 256)));
          default: program_regs(lo, hi, CFG_W'($urandom_range(0, 4 * 256)));
        endcase
      end
      calm = (phase % 3 == 2);
      target = n_points + RAND_PTS / 7;
      while (n_points < target) begin
        if ($urandom_range(0, 9) == 0) send_path_run($urandom_range(9, 20));
        else send_path_run($urandom_range(1, 8));
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_output_stall();
    quiesce();
    calm = 1'b1;
    hold_req = HOLD_OFF;
    repeat (8) send_path_run(3);
    calm = 1'b0;
    quiesce();
  endtask

  initial begin
    err_cnt     = 0;
    n_points    = 0;
    n_runs      = 0;
    n_cfg       = 0;
    n_checked   = 0;
    n_reached   = 0;
    n_zero_rate = 0;
    n_sat       = 0;
    calm        = 1'b0;
    hold_req    = 0;
    reset_mirror();
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    in_if.valid         <= 1'b0;
    in_if.point_x       <= '0;
    in_if.point_y       <= '0;
    in_if.current_speed <= '0;
    in_if.target_speed  <= '0;
    in_if.last_point    <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_points();
    test_cfg_extremes();
    test_random_runs();
    test_output_stall();

    quiesce();
    if (pending_steer_q.size() != 0) begin
      err_cnt++;
      $display("%0d results never arrived", pending_steer_q.size());
    end
    $display("%0d points in %0d runs over %0d register settings, %0d results checked",
             n_points, n_runs, n_cfg, n_checked);
    $display("%0d reached lookahead, %0d zero rate, %0d saturated rate, %0d errors",
             n_reached, n_zero_rate, n_sat, err_cnt);
    if (err_cnt == 0) begin
      $display("pure_pursuit_steering_top test passed");
    end else begin
      $display("pure_pursuit_steering_top test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ppsteer_pkg.sv
rtl/ppsteer_if.sv
rtl/ppsteer_mul.sv
rtl/ppsteer_div.sv
rtl/ppsteer_seq.sv
rtl/pure_pursuit_steering_top.sv
tb/tb_pure_pursuit_steering_top.sv
